### rtl/vrtp_pkg.sv
// Package with shared types and constants for the Vorbis RTP payload depacketizer.
`default_nettype none

package vrtp_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QPtrW      = $clog2(QueueDepth);
    localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

    localparam logic [15:0] HdrDescPos = 16'd3;
    localparam logic [15:0] ShortBody  = 16'd6;
    localparam logic [15:0] FragHdrLen = 16'd6;
    localparam logic [15:0] PosMax     = 16'hffff;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_FLEN_LO = 3'd1,
        PH_FLEN_HI = 3'd2,
        PH_ULEN_LO = 3'd3,
        PH_ULEN_HI = 3'd4,
        PH_UDATA   = 3'd5,
        PH_FDATA   = 3'd6,
        PH_IDLE    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        FRAG_NONE   = 2'd0,
        FRAG_START  = 2'd1,
        FRAG_MIDDLE = 2'd2,
        FRAG_END    = 2'd3
    } frag_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_LAST  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        kind_t      kind;
        logic       packet_start;
        logic [1:0] packet_type;
    } result_t;

endpackage

`default_nettype wire

### rtl/vrtp_in_if.sv
// Input channel interface: payload body bytes with their datagram length.
`default_nettype none

interface vrtp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        first_of_datagram;
    logic [15:0] datagram_length;

    modport source (output valid, output byte_value, output first_of_datagram,
                    output datagram_length, input ready);
    modport sink   (input valid, input byte_value, input first_of_datagram,
                    input datagram_length, output ready);
endinterface

`default_nettype wire

### rtl/vrtp_out_if.sv
// Output channel interface: reassembled packet bytes and packet markers.
`default_nettype none

interface vrtp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic       packet_start;
    logic [1:0] packet_type;

    modport source (output valid, output data_byte, output kind, output packet_start,
                    output packet_type, input ready);
    modport sink   (input valid, input data_byte, input kind, input packet_start,
                    input packet_type, output ready);
endinterface

`default_nettype wire

### rtl/vrtp_parser.sv
// Front end: parses payload bytes and produces at most one result per accepted beat.
`default_nettype none

module vrtp_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        byte_value,
    input  wire logic              first_of_datagram,
    input  wire logic [15:0]       datagram_length,
    output      logic              res_valid,
    output      vrtp_pkg::result_t res
);

    vrtp_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      pos_reg, pos_next;
    logic [1:0]       frag_reg, frag_next;
    logic [1:0]       type_reg, type_next;
    logic [3:0]       left_reg, left_next;
    logic [7:0]       lenlo_reg, lenlo_next;
    logic [15:0]      bleft_reg, bleft_next;
    logic             open_reg, open_next;
    logic             nis_reg, nis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vrtp_pkg::PH_HEADER;
            pos_reg   <= '0;
            frag_reg  <= '0;
            type_reg  <= '0;
            left_reg  <= '0;
            lenlo_reg <= '0;
            bleft_reg <= '0;
            open_reg  <= 1'b0;
            nis_reg   <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            frag_reg  <= frag_next;
            type_reg  <= type_next;
            left_reg  <= left_next;
            lenlo_reg <= lenlo_next;
            bleft_reg <= bleft_next;
            open_reg  <= open_next;
            nis_reg   <= nis_next;
        end
    end

    always_comb
    begin
        vrtp_pkg::phase_t ph;
        logic [15:0] pos;
        logic [15:0] rem;
        logic [15:0] amount;
        logic [15:0] bleft_dec;
        logic        fits;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        frag_next  = frag_reg;
        type_next  = type_reg;
        left_next  = left_reg;
        lenlo_next = lenlo_reg;
        bleft_next = bleft_reg;
        open_next  = open_reg;
        nis_next   = nis_reg;
        res_valid  = 1'b0;
        res        = '0;

        ph        = phase_reg;
        pos       = pos_reg;
        rem       = 16'd0;
        amount    = {byte_value, lenlo_reg};
        bleft_dec = bleft_reg - 16'd1;
        fits      = 1'b0;

        if (accept)
        begin
            // A new body interrupts any unfinished unfragmented packet.
            if (first_of_datagram)
            begin
                if (phase_reg == vrtp_pkg::PH_UDATA && open_reg)
                begin
                    res_valid        = 1'b1;
                    res.kind         = vrtp_pkg::KIND_ABORT;
                    res.packet_type  = type_reg;
                    open_next        = 1'b0;
                    nis_next         = 1'b1;
                end
                ph  = vrtp_pkg::PH_HEADER;
                pos = '0;
            end

            rem = (pos < datagram_length) ? (datagram_length - pos) : 16'd0;

            unique case (ph)
                vrtp_pkg::PH_HEADER:
                begin
                    phase_next = vrtp_pkg::PH_HEADER;
                    if (pos == vrtp_pkg::HdrDescPos)
                    begin
                        if (datagram_length <= vrtp_pkg::ShortBody)
                        begin
                            phase_next = vrtp_pkg::PH_IDLE;
                        end
                        else
                        begin
                            frag_next = byte_value[1:0];
                            if (byte_value[1:0] == vrtp_pkg::FRAG_NONE ||
                                byte_value[1:0] == vrtp_pkg::FRAG_START)
                            begin
                                if (open_reg)
                                begin
                                    res_valid       = 1'b1;
                                    res.kind        = vrtp_pkg::KIND_ABORT;
                                    res.packet_type = type_reg;
                                    open_next       = 1'b0;
                                end
                                nis_next = 1'b1;
                            end
                            type_next  = byte_value[3:2];
                            left_next  = byte_value[7:4];
                            phase_next = (byte_value[1:0] == vrtp_pkg::FRAG_NONE) ?
                                         vrtp_pkg::PH_ULEN_LO : vrtp_pkg::PH_FLEN_LO;
                        end
                    end
                end
                vrtp_pkg::PH_ULEN_LO:
                begin
                    if (rem > 16'd2 && left_reg != 4'd0)
                    begin
                        lenlo_next = byte_value;
                        phase_next = vrtp_pkg::PH_ULEN_HI;
                    end
                    else
                    begin
                        phase_next = vrtp_pkg::PH_IDLE;
                    end
                end
                vrtp_pkg::PH_ULEN_HI:
                begin
                    // Remaining bytes are counted from both length bytes, low byte first.
                    if (amount != 16'd0 &&
                        ({1'b0, amount} + 17'd2) <= ({1'b0, rem} + 17'd1))
                    begin
                        bleft_next = amount;
                        nis_next   = 1'b1;
                        phase_next = vrtp_pkg::PH_UDATA;
                    end
                    else
                    begin
                        left_next  = left_reg - 4'd1;
                        phase_next = vrtp_pkg::PH_ULEN_LO;
                    end
                end
                vrtp_pkg::PH_UDATA:
                begin
                    bleft_next       = bleft_dec;
                    res_valid        = 1'b1;
                    res.data_byte    = byte_value;
                    res.packet_start = nis_next;
                    res.packet_type  = type_reg;
                    if (bleft_dec == 16'd0)
                    begin
                        res.kind   = vrtp_pkg::KIND_LAST;
                        left_next  = left_reg - 4'd1;
                        open_next  = 1'b0;
                        nis_next   = 1'b1;
                        phase_next = vrtp_pkg::PH_ULEN_LO;
                    end
                    else
                    begin
                        res.kind  = vrtp_pkg::KIND_DATA;
                        open_next = 1'b1;
                        nis_next  = 1'b0;
                    end
                end
                vrtp_pkg::PH_FLEN_LO:
                begin
                    if (pos >= vrtp_pkg::HdrDescPos + 16'd1)
                    begin
                        lenlo_next = byte_value;
                        phase_next = vrtp_pkg::PH_FLEN_HI;
                    end
                end
                vrtp_pkg::PH_FLEN_HI:
                begin
                    fits = (datagram_length > vrtp_pkg::FragHdrLen) &&
                           (amount <= datagram_length - vrtp_pkg::FragHdrLen);
                    if (fits && amount != 16'd0)
                    begin
                        bleft_next = amount;
                        phase_next = vrtp_pkg::PH_FDATA;
                    end
                    else
                    begin
                        // A bad end fragment still closes the packet.
                        if (frag_reg == vrtp_pkg::FRAG_END)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = vrtp_pkg::KIND_END;
                            res.packet_start = nis_next;
                            res.packet_type  = type_reg;
                            open_next        = 1'b0;
                            nis_next         = 1'b1;
                        end
                        phase_next = vrtp_pkg::PH_IDLE;
                    end
                end
                vrtp_pkg::PH_FDATA:
                begin
                    bleft_next       = bleft_dec;
                    res_valid        = 1'b1;
                    res.data_byte    = byte_value;
                    res.packet_start = nis_next;
                    res.packet_type  = type_reg;
                    if (bleft_dec == 16'd0 && frag_reg == vrtp_pkg::FRAG_END)
                    begin
                        res.kind   = vrtp_pkg::KIND_LAST;
                        open_next  = 1'b0;
                        nis_next   = 1'b1;
                        phase_next = vrtp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        res.kind  = vrtp_pkg::KIND_DATA;
                        open_next = 1'b1;
                        nis_next  = 1'b0;
                        if (bleft_dec == 16'd0)
                        begin
                            phase_next = vrtp_pkg::PH_IDLE;
                        end
                    end
                end
                vrtp_pkg::PH_IDLE:
                begin
                    phase_next = vrtp_pkg::PH_IDLE;
                end
                default:
                begin
                    phase_next = vrtp_pkg::PH_IDLE;
                end
            endcase

            pos_next = (pos != vrtp_pkg::PosMax) ? (pos + 16'd1) : pos;
        end
    end

endmodule

`default_nettype wire

### rtl/vrtp_queue.sv
// Back end: short result queue that drives the output channel.
`default_nettype none

module vrtp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire vrtp_pkg::result_t push_data,
    output      logic              full,
    output      logic              pop_valid,
    input  wire logic              pop_ready,
    output      vrtp_pkg::result_t pop_data
);

    vrtp_pkg::result_t                 mem_reg [vrtp_pkg::QueueDepth];
    logic [vrtp_pkg::QPtrW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [vrtp_pkg::QPtrW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [vrtp_pkg::QCntW-1:0]        count_reg, count_next;
    logic                              pop;

    assign pop       = pop_valid && pop_ready;
    assign full      = (count_reg == vrtp_pkg::QCntW'(vrtp_pkg::QueueDepth));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/vorbis_rtp_payload_depacketizer_core.sv
// Top level of the Vorbis RTP payload depacketizer: parser front end and result queue.
`default_nettype none

// Channel   Role    Beat carries
// --------  ------  ---------------------------------------------------------
// in_ch     sink    byte_value, first_of_datagram, datagram_length
// out_ch    source  data_byte, kind, packet_start, packet_type
//
// One input beat is taken every cycle while the result queue has room; the
// parser settles all of its state for a byte in the cycle that accepts it.
// Each accepted beat yields zero or one result, written into a four-entry
// queue whose head drives out_ch. When out_ch stalls, the queue absorbs results
// until it is full, and only then does in_ch ready drop. Reset (rst_n low,
// asynchronous) empties the queue and returns the parser to header parsing with
// no packet open.

module vorbis_rtp_payload_depacketizer_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    vrtp_in_if.sink    in_ch,
    vrtp_out_if.source out_ch
);

    logic              accept;
    logic              res_valid;
    logic              q_full;
    vrtp_pkg::result_t res;
    vrtp_pkg::result_t head;

    // Input is taken whenever the queue can hold a possible result.
    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    vrtp_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .byte_value        (in_ch.byte_value),
        .first_of_datagram (in_ch.first_of_datagram),
        .datagram_length   (in_ch.datagram_length),
        .res_valid         (res_valid),
        .res               (res)
    );

    vrtp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .pop_valid (out_ch.valid),
        .pop_ready (out_ch.ready),
        .pop_data  (head)
    );

    assign out_ch.data_byte    = head.data_byte;
    assign out_ch.kind         = head.kind;
    assign out_ch.packet_start = head.packet_start;
    assign out_ch.packet_type  = head.packet_type;

endmodule

`default_nettype wire

### rtl/vrtp_checker.sv
// Port-level checker for the depacketizer, bound to the top level.
`default_nettype none

module vrtp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] data_byte,
    input wire logic [1:0] kind,
    input wire logic       packet_start,
    input wire logic [1:0] packet_type
);

    // The output side is empty while reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({data_byte, kind, packet_start, packet_type}))
        else $error("output payload changed while stalled");

    // An abort never opens a packet and carries no byte.
    a_abort_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == vrtp_pkg::KIND_ABORT |-> !packet_start && data_byte == 8'd0)
        else $error("malformed abort result");

    a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == vrtp_pkg::KIND_END |-> data_byte == 8'd0)
        else $error("packet end result carries a byte");

endmodule

bind vorbis_rtp_payload_depacketizer_core vrtp_checker u_vrtp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .data_byte    (out_ch.data_byte),
    .kind         (out_ch.kind),
    .packet_start (out_ch.packet_start),
    .packet_type  (out_ch.packet_type)
);

`default_nettype wire
